### sv/bfi_pkg.sv
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared constants, codes and controller/datapath interface types for the
// brainfuck interpreter block.
// ----------------------------------------------------------------------------
package bfi_pkg;

    localparam int TAPE_DEPTH = 32768;
    localparam int PROG_DEPTH = 4096;

    localparam int TAPE_AW = $clog2(TAPE_DEPTH);
    localparam int FILL_W  = $clog2(TAPE_DEPTH + 1);
    localparam int PROG_AW = $clog2(PROG_DEPTH);
    localparam int PC_W    = $clog2(PROG_DEPTH + 1);

    localparam int OP_W     = 2;
    localparam int PADDR_W  = 12;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int IADDR_W  = 13;
    localparam int LEN_W    = 13;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    localparam logic REG_PROGRAM_LENGTH = 1'b0;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [STATUS_W-1:0] ST_RUN   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OPEN  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLOSE = 3'd5;

    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

    typedef struct packed {
        logic accept;
        logic exec;
        logic freq;
        logic fchk;
        logic breq;
        logic bchk;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic go_fwd;
        logic go_bwd;
        logic fbound;
        logic bbound;
        logic fmatch;
        logic bmatch;
    } t_stat;

endpackage

### sv/bfi_ctrl.sv
// ----------------------------------------------------------------------------
// bfi_ctrl
// Sequencer for the interpreter: accepts a word, runs the execute step and
// steps the bracket scans, holding a finishing step until the result register
// is free.
// ----------------------------------------------------------------------------
module bfi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bfi_pkg::t_stat i_stat,
    output bfi_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_FREQ = 6'b000100,
        S_FCHK = 6'b001000,
        S_BREQ = 6'b010000,
        S_BCHK = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.go_fwd) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_FREQ;
                end else if (i_stat.go_bwd) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_BREQ;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FREQ: begin
                if (!i_stat.fbound) begin
                    o_cmd.freq = 1'b1;
                    n_state    = S_FCHK;
                end else if (i_stat.out_free) begin
                    o_cmd.freq = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FCHK: begin
                if (!i_stat.fmatch) begin
                    o_cmd.fchk = 1'b1;
                    n_state    = S_FREQ;
                end else if (i_stat.out_free) begin
                    o_cmd.fchk = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_BREQ: begin
                if (!i_stat.bbound) begin
                    o_cmd.breq = 1'b1;
                    n_state    = S_BCHK;
                end else if (i_stat.out_free) begin
                    o_cmd.breq = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_BCHK: begin
                if (!i_stat.bmatch) begin
                    o_cmd.bchk = 1'b1;
                    n_state    = S_BREQ;
                end else if (i_stat.out_free) begin
                    o_cmd.bchk = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### sv/bfi_dp.sv
// ----------------------------------------------------------------------------
// bfi_dp
// Interpreter datapath: program store, tape with fill count, pointers,
// nesting counter, status, length register and the result register.
// ----------------------------------------------------------------------------
module bfi_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bfi_pkg::t_cmd                  i_cmd,
    output bfi_pkg::t_stat                 o_stat,
    input  logic [bfi_pkg::OP_W-1:0]       i_op,
    input  logic [bfi_pkg::PADDR_W-1:0]    i_program_address,
    input  logic [bfi_pkg::BYTE_W-1:0]     i_program_byte,
    input  logic [bfi_pkg::BYTE_W-1:0]     i_input_byte,
    input  logic                           i_input_eof,
    input  logic                           i_cfg_we,
    input  logic [bfi_pkg::LEN_W-1:0]      i_cfg_wdata,
    output logic [bfi_pkg::LEN_W-1:0]      o_cfg_len,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [bfi_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_output_valid,
    output logic [bfi_pkg::BYTE_W-1:0]     o_output_byte,
    output logic                           o_input_taken,
    output logic [bfi_pkg::IADDR_W-1:0]    o_instruction_address
);

    logic [bfi_pkg::BYTE_W-1:0] r_prog_mem [bfi_pkg::PROG_DEPTH];
    logic [bfi_pkg::BYTE_W-1:0] r_tape_mem [bfi_pkg::TAPE_DEPTH];

    logic [bfi_pkg::PC_W-1:0]     r_pc,     n_pc;
    logic [bfi_pkg::TAPE_AW-1:0]  r_ptr,    n_ptr;
    logic [bfi_pkg::FILL_W-1:0]   r_fill,   n_fill;
    logic [bfi_pkg::PC_W-1:0]     r_nest,   n_nest;
    logic [bfi_pkg::PC_W-1:0]     r_scan,   n_scan;
    logic [bfi_pkg::STATUS_W-1:0] r_status, n_status;
    logic [bfi_pkg::LEN_W-1:0]    r_len;
    logic                         r_ov;

    logic [bfi_pkg::OP_W-1:0]    r_op;
    logic [bfi_pkg::PROG_AW-1:0] r_paddr;
    logic [bfi_pkg::BYTE_W-1:0]  r_pbyte;
    logic [bfi_pkg::BYTE_W-1:0]  r_ibyte;
    logic                        r_eof;
    logic [bfi_pkg::BYTE_W-1:0]  r_pdata;
    logic [bfi_pkg::BYTE_W-1:0]  r_tdata;

    logic [bfi_pkg::STATUS_W-1:0] r_res_status;
    logic                         r_res_valid;
    logic [bfi_pkg::BYTE_W-1:0]   r_res_byte;
    logic                         r_res_taken;
    logic [bfi_pkg::IADDR_W-1:0]  r_res_addr;

    logic [bfi_pkg::PC_W-1:0]    eff_len;
    logic [bfi_pkg::BYTE_W-1:0]  cur_cell;
    logic                        at_end;
    logic                        step_run;
    logic                        ptr_at_fill;
    logic [bfi_pkg::PC_W:0]      scan_inc;
    logic                        prog_re;
    logic                        prog_we;
    logic [bfi_pkg::PROG_AW-1:0] prog_raddr;
    logic                        tape_we;
    logic [bfi_pkg::BYTE_W-1:0]  tape_wdata;
    logic                        res_load;
    logic                        res_valid;
    logic [bfi_pkg::BYTE_W-1:0]  res_byte;
    logic                        res_taken;

    // clamp the program length to the store depth
    always_comb begin
        if (int'(r_len) > bfi_pkg::PROG_DEPTH) begin
            eff_len = bfi_pkg::PC_W'(bfi_pkg::PROG_DEPTH);
        end else begin
            eff_len = bfi_pkg::PC_W'(r_len);
        end
    end

    // cells at or above the fill count read as zero
    assign ptr_at_fill = (bfi_pkg::FILL_W'(r_ptr) == r_fill);
    assign cur_cell    = (bfi_pkg::FILL_W'(r_ptr) < r_fill) ? r_tdata : '0;
    assign at_end      = (r_pc >= eff_len);
    assign step_run    = (r_op == bfi_pkg::OP_STEP) && (r_status == bfi_pkg::ST_RUN) && !at_end;
    assign scan_inc    = {1'b0, r_scan} + 1'b1;

    assign o_stat.out_free = !r_ov || !i_out_stall;
    assign o_stat.go_fwd   = step_run && (r_pdata == bfi_pkg::CH_OPEN) && (cur_cell == '0);
    assign o_stat.go_bwd   = step_run && (r_pdata == bfi_pkg::CH_CLOSE);
    assign o_stat.fbound   = (scan_inc >= {1'b0, eff_len});
    assign o_stat.bbound   = (r_scan == '0) ||
                             (r_scan > bfi_pkg::PC_W'(bfi_pkg::PROG_DEPTH));
    assign o_stat.fmatch   = (r_pdata == bfi_pkg::CH_CLOSE) && (r_nest == bfi_pkg::PC_W'(1));
    assign o_stat.bmatch   = (r_pdata == bfi_pkg::CH_OPEN) && (r_nest == bfi_pkg::PC_W'(1));

    assign prog_re = i_cmd.accept || i_cmd.freq || i_cmd.breq;

    always_comb begin
        if (i_cmd.accept) begin
            prog_raddr = bfi_pkg::PROG_AW'(r_pc);
        end else if (i_cmd.freq) begin
            prog_raddr = bfi_pkg::PROG_AW'(scan_inc);
        end else begin
            prog_raddr = bfi_pkg::PROG_AW'(r_scan - bfi_pkg::PC_W'(1));
        end
    end

    always_comb begin
        n_pc       = r_pc;
        n_ptr      = r_ptr;
        n_fill     = r_fill;
        n_nest     = r_nest;
        n_scan     = r_scan;
        n_status   = r_status;
        prog_we    = 1'b0;
        tape_we    = 1'b0;
        tape_wdata = '0;
        res_load   = 1'b0;
        res_valid  = 1'b0;
        res_byte   = '0;
        res_taken  = 1'b0;

        if (i_cmd.exec) begin
            case (r_op)
                bfi_pkg::OP_LOAD: begin
                    prog_we  = 1'b1;
                    res_load = 1'b1;
                end
                bfi_pkg::OP_RESTART: begin
                    n_pc     = '0;
                    n_ptr    = '0;
                    n_fill   = '0;
                    n_nest   = '0;
                    n_status = bfi_pkg::ST_RUN;
                    res_load = 1'b1;
                end
                bfi_pkg::OP_STEP: begin
                    res_load = 1'b1;
                    if (r_status != bfi_pkg::ST_RUN) begin
                        n_status = r_status;
                    end else if (at_end) begin
                        n_status = bfi_pkg::ST_END;
                    end else begin
                        case (r_pdata)
                            bfi_pkg::CH_LEFT: begin
                                if (r_ptr == '0) begin
                                    n_status = bfi_pkg::ST_UNDER;
                                end else begin
                                    n_ptr = r_ptr - bfi_pkg::TAPE_AW'(1);
                                    n_pc  = r_pc + bfi_pkg::PC_W'(1);
                                end
                            end
                            bfi_pkg::CH_RIGHT: begin
                                if (r_ptr >= bfi_pkg::TAPE_AW'(bfi_pkg::TAPE_DEPTH - 1)) begin
                                    n_status = bfi_pkg::ST_OVER;
                                end else begin
                                    // zero the cell left behind at the fill edge
                                    if (ptr_at_fill) begin
                                        tape_we = 1'b1;
                                        n_fill  = r_fill + bfi_pkg::FILL_W'(1);
                                    end
                                    n_ptr = r_ptr + bfi_pkg::TAPE_AW'(1);
                                    n_pc  = r_pc + bfi_pkg::PC_W'(1);
                                end
                            end
                            bfi_pkg::CH_PLUS, bfi_pkg::CH_MINUS, bfi_pkg::CH_COMMA: begin
                                tape_we = 1'b1;
                                if (ptr_at_fill) begin
                                    n_fill = r_fill + bfi_pkg::FILL_W'(1);
                                end
                                if (r_pdata == bfi_pkg::CH_PLUS) begin
                                    tape_wdata = cur_cell + bfi_pkg::BYTE_W'(1);
                                end else if (r_pdata == bfi_pkg::CH_MINUS) begin
                                    tape_wdata = cur_cell - bfi_pkg::BYTE_W'(1);
                                end else if (r_eof) begin
                                    tape_wdata = '1;
                                end else begin
                                    tape_wdata = r_ibyte;
                                    res_taken  = 1'b1;
                                end
                                n_pc = r_pc + bfi_pkg::PC_W'(1);
                            end
                            bfi_pkg::CH_DOT: begin
                                res_valid = 1'b1;
                                res_byte  = cur_cell;
                                n_pc      = r_pc + bfi_pkg::PC_W'(1);
                            end
                            bfi_pkg::CH_OPEN: begin
                                if (cur_cell == '0) begin
                                    n_scan   = r_pc;
                                    n_nest   = bfi_pkg::PC_W'(1);
                                    res_load = 1'b0;
                                end else begin
                                    n_pc = r_pc + bfi_pkg::PC_W'(1);
                                end
                            end
                            bfi_pkg::CH_CLOSE: begin
                                n_scan   = r_pc;
                                n_nest   = bfi_pkg::PC_W'(1);
                                res_load = 1'b0;
                            end
                            default: begin
                                n_pc = r_pc + bfi_pkg::PC_W'(1);
                            end
                        endcase
                    end
                end
                default: begin
                    res_load = 1'b1;
                end
            endcase
        end else if (i_cmd.freq) begin
            if (o_stat.fbound) begin
                n_status = bfi_pkg::ST_OPEN;
                n_nest   = '0;
                res_load = 1'b1;
            end
        end else if (i_cmd.fchk) begin
            n_scan = bfi_pkg::PC_W'(scan_inc);
            if (r_pdata == bfi_pkg::CH_OPEN) begin
                n_nest = r_nest + bfi_pkg::PC_W'(1);
            end else if (r_pdata == bfi_pkg::CH_CLOSE) begin
                n_nest = r_nest - bfi_pkg::PC_W'(1);
            end
            if (o_stat.fmatch) begin
                n_pc     = bfi_pkg::PC_W'(scan_inc) + bfi_pkg::PC_W'(1);
                res_load = 1'b1;
            end
        end else if (i_cmd.breq) begin
            if (o_stat.bbound) begin
                n_status = bfi_pkg::ST_CLOSE;
                n_nest   = '0;
                res_load = 1'b1;
            end
        end else if (i_cmd.bchk) begin
            n_scan = r_scan - bfi_pkg::PC_W'(1);
            if (r_pdata == bfi_pkg::CH_CLOSE) begin
                n_nest = r_nest + bfi_pkg::PC_W'(1);
            end else if (r_pdata == bfi_pkg::CH_OPEN) begin
                n_nest = r_nest - bfi_pkg::PC_W'(1);
            end
            if (o_stat.bmatch) begin
                n_pc     = r_scan - bfi_pkg::PC_W'(1);
                res_load = 1'b1;
            end
        end
    end

    // program store
    always_ff @(posedge i_clk) begin
        if (prog_we) begin
            r_prog_mem[r_paddr] <= r_pbyte;
        end
        if (prog_re) begin
            r_pdata <= r_prog_mem[prog_raddr];
        end
    end

    // tape
    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape_mem[r_ptr] <= tape_wdata;
        end
        if (i_cmd.accept) begin
            r_tdata <= r_tape_mem[r_ptr];
        end
    end

    // input word and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_paddr <= bfi_pkg::PROG_AW'(i_program_address);
            r_pbyte <= i_program_byte;
            r_ibyte <= i_input_byte;
            r_eof   <= i_input_eof;
        end
        if (res_load) begin
            r_res_status <= n_status;
            r_res_valid  <= res_valid;
            r_res_byte   <= res_byte;
            r_res_taken  <= res_taken;
            r_res_addr   <= bfi_pkg::IADDR_W'(n_pc);
        end
        r_scan <= n_scan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_ptr    <= '0;
            r_fill   <= '0;
            r_nest   <= '0;
            r_status <= bfi_pkg::ST_RUN;
            r_len    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_ptr    <= n_ptr;
            r_fill   <= n_fill;
            r_nest   <= n_nest;
            r_status <= n_status;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (res_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_cfg_len             = r_len;
    assign o_out_valid           = r_ov;
    assign o_status              = r_res_status;
    assign o_output_valid        = r_res_valid;
    assign o_output_byte         = r_res_byte;
    assign o_input_taken         = r_res_taken;
    assign o_instruction_address = r_res_addr;

endmodule

### sv/brainfuck_interpreter.sv
// ----------------------------------------------------------------------------
// brainfuck_interpreter
// Runs a program from an on-chip program store over an 8-bit wrapping tape.
//
// Input channel (i_in_valid / o_in_stall): one word per command. op 0 writes
// i_program_byte at i_program_address, op 1 executes one instruction, op 2
// restarts (tape, pointers and status cleared, program kept).
// Output channel (o_out_valid / i_out_stall): exactly one result word per
// input word, in order: status, emitted byte, input-taken flag and the
// program counter after the command.
// Configuration: APB register 0 holds program_length; pready is always high.
// A word is accepted in S_IDLE and executed in S_EXEC of the sequencer; a
// bracket scan then walks the program a byte at a time through a read and a
// check state, as the program store has a single read port.
// The result sits in an output register; while it is stalled the next word is
// still accepted and its final step waits until the register frees up.
// Reset (synchronous, active low) clears pointers, status, program_length and
// the tape fill count; the tape reads as zero at or above the fill count, so
// there is no clearing pass. The program store is not cleared.
// ----------------------------------------------------------------------------
module brainfuck_interpreter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bfi_pkg::OP_W-1:0]       i_op,
    input  logic [bfi_pkg::PADDR_W-1:0]    i_program_address,
    input  logic [bfi_pkg::BYTE_W-1:0]     i_program_byte,
    input  logic [bfi_pkg::BYTE_W-1:0]     i_input_byte,
    input  logic                           i_input_eof,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bfi_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_output_valid,
    output logic [bfi_pkg::BYTE_W-1:0]     o_output_byte,
    output logic                           o_input_taken,
    output logic [bfi_pkg::IADDR_W-1:0]    o_instruction_address,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfi_pkg::CFG_AW-1:0]     paddr,
    input  logic [bfi_pkg::CFG_DW-1:0]     pwdata,
    output logic [bfi_pkg::CFG_DW-1:0]     prdata,
    output logic                           pready
);

    bfi_pkg::t_cmd              cmd;
    bfi_pkg::t_stat             stat;
    logic                       cfg_we;
    logic                       cfg_hit;
    logic [bfi_pkg::LEN_W-1:0]  cfg_len;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[bfi_pkg::CFG_AW-1] == bfi_pkg::REG_PROGRAM_LENGTH);
    assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? bfi_pkg::CFG_DW'(cfg_len) : '0;

    bfi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bfi_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_op                  (i_op),
        .i_program_address     (i_program_address),
        .i_program_byte        (i_program_byte),
        .i_input_byte          (i_input_byte),
        .i_input_eof           (i_input_eof),
        .i_cfg_we              (cfg_we),
        .i_cfg_wdata           (pwdata[bfi_pkg::LEN_W-1:0]),
        .o_cfg_len             (cfg_len),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_status              (o_status),
        .o_output_valid        (o_output_valid),
        .o_output_byte         (o_output_byte),
        .o_input_taken         (o_input_taken),
        .o_instruction_address (o_instruction_address)
    );

    // an accepted word always occupies the sequencer for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // no datapath work while the input side is open
    a_idle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !(cmd.exec || cmd.freq || cmd.fchk || cmd.breq || cmd.bchk))
        else $error("datapath command issued while idle");

    // a new result word only follows a finishing step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(cmd.exec || cmd.freq || cmd.fchk || cmd.breq || cmd.bchk))
        else $error("result word without a finishing step");

endmodule
